/* sv/dsrm_pkg.sv */
// shared types, constants and register codes of the deep sample range merge block
package dsrm_pkg;

	localparam int DEPTH_W        = 32;
	localparam int ALPHA_W        = 17;
	localparam int COLOR_W        = 24;
	localparam int COUNT_W        = 10;
	localparam int TRANS_W        = 33;
	localparam int COLOR_CHANNELS = 3;
	localparam int MAX_SAMPLES    = 1024;
	localparam int FIFO_DEPTH     = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_BY_DEPTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LIMIT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_HIDDEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GIVE_VOLUME     = 3'd4;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
	localparam logic [TRANS_W-1:0] UNITY_T    = 33'h1_0000_0000;
	localparam logic [TRANS_W-1:0] OPAQUE_EPS = 33'd4295;
	localparam logic [COLOR_W-1:0] COLOR_MAX  = 24'hFF_FFFF;

	localparam logic        RST_SCALE_BY_DEPTH  = 1'b1;
	localparam logic [31:0] RST_DISTANCE_LIMIT  = 32'd3277;
	localparam logic [16:0] RST_ALPHA_LIMIT     = 17'd8192;
	localparam logic        RST_COLLAPSE_HIDDEN = 1'b1;
	localparam logic        RST_GIVE_VOLUME     = 1'b1;

	typedef struct packed {
		logic [DEPTH_W-1:0] front_depth;
		logic [DEPTH_W-1:0] back_depth;
		logic [ALPHA_W-1:0] alpha;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               pixel_last;
	} in_item_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] out_front;
		logic [DEPTH_W-1:0] out_back;
		logic [ALPHA_W-1:0] out_alpha;
		logic [COLOR_W-1:0] out_red;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_blue;
		logic [COUNT_W-1:0] merged_count;
		logic               last_of_pixel;
	} out_item_t;

	typedef struct packed {
		logic               scale_by_depth;
		logic [DEPTH_W-1:0] distance_limit;
		logic [ALPHA_W-1:0] alpha_limit;
		logic               collapse_hidden;
		logic               give_volume;
	} cfg_t;

	// results produced by one sample, in delivery order
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  first;
		out_item_t  second;
	} push_t;

endpackage

/* sv/dsrm_core.sv */
// merge decision, running range state and result formatting, one sample per cycle while fire is high
module dsrm_core #(
	parameter int MAX_SAMPLES = dsrm_pkg::MAX_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  dsrm_pkg::in_item_t item,
	input  dsrm_pkg::cfg_t     cfg,
	output dsrm_pkg::push_t    push
);

	localparam int CH     = dsrm_pkg::COLOR_CHANNELS;
	localparam int CW     = dsrm_pkg::COLOR_W;
	localparam int CAP_I  = (MAX_SAMPLES - 1 < 1023) ? MAX_SAMPLES - 1 : 1023;
	localparam logic [dsrm_pkg::COUNT_W-1:0] COUNT_CAP = dsrm_pkg::COUNT_W'(CAP_I);

	logic [31:0] prior_front_q, prior_back_q;
	logic [16:0] prior_alpha_q;
	logic        range_open_q, hidden_q;
	logic [32:0] pix_t_q, rng_t_q;
	logic [CW-1:0] rng_color_q [CH];
	logic [31:0] near_front_q, far_back_q;
	logic [9:0]  count_q;

	logic [32:0] n_pix_t, n_rng_t;
	logic        n_open, n_hidden;
	logic [CW-1:0] n_color [CH];
	logic [31:0] n_near, n_far;
	logic [9:0]  n_count;

	logic [CW-1:0] src [CH];
	logic [56:0]   col_prod [CH];
	logic [24:0]   col_sum [CH];
	logic [CW-1:0] col_abs [CH];

	logic [16:0] a_cl, factor;
	logic [49:0] pt_prod, rt_prod;
	logic [32:0] pt_new, rt_abs, rt_open;
	logic [32:0] s_cur, s_pri, gap;
	logic [33:0] sum4;
	logic [17:0] a_sum, a_lim2;
	logic [49:0] left, hi, lo, diff;
	logic        alpha_ok, dist_ok, hid, collapse_now, do_absorb, emit_early;
	dsrm_pkg::out_item_t old_out, new_out;

	function automatic dsrm_pkg::out_item_t make_out(
		input logic [31:0] near, input logic [31:0] far, input logic [32:0] rt,
		input logic [CW-1:0] r, input logic [CW-1:0] g, input logic [CW-1:0] b,
		input logic [9:0] cnt, input logic last, input logic gv);
		dsrm_pkg::out_item_t o;
		logic [32:0] opac;
		opac            = dsrm_pkg::UNITY_T - rt;
		o.out_front     = near;
		o.out_back      = gv ? far : near;
		o.out_alpha     = opac[32:16];
		o.out_red       = r;
		o.out_green     = g;
		o.out_blue      = b;
		o.merged_count  = cnt;
		o.last_of_pixel = last;
		return o;
	endfunction

	assign src[0] = item.red;
	assign src[1] = item.green;
	assign src[2] = item.blue;

	// clamp alpha to one, transparency factor in q1.16
	assign a_cl    = (item.alpha > dsrm_pkg::ALPHA_ONE) ? dsrm_pkg::ALPHA_ONE : item.alpha;
	assign factor  = dsrm_pkg::ALPHA_ONE - a_cl;
	assign pt_prod = 50'(pix_t_q) * 50'(factor);
	assign pt_new  = pt_prod[48:16];
	assign rt_prod = 50'(rng_t_q) * 50'(factor);
	assign rt_abs  = rt_prod[48:16];
	assign rt_open = {factor, 16'b0};

	always_comb begin
		for (int c = 0; c < CH; c++) begin
			col_prod[c] = 57'(rng_t_q) * 57'(src[c]);
			col_sum[c]  = 25'(rng_color_q[c]) + 25'(col_prod[c][55:32]);
			col_abs[c]  = col_sum[c][24] ? dsrm_pkg::COLOR_MAX : col_sum[c][23:0];
		end
	end

	// neighbor test against the previous sample
	assign s_cur    = 33'(item.front_depth) + 33'(item.back_depth);
	assign s_pri    = 33'(prior_front_q) + 33'(prior_back_q);
	assign gap      = (s_cur > s_pri) ? s_cur - s_pri : s_pri - s_cur;
	assign a_sum    = 18'(prior_alpha_q) + 18'(a_cl);
	assign a_lim2   = {cfg.alpha_limit, 1'b0};
	assign alpha_ok = a_sum < a_lim2;
	assign sum4     = 34'(s_cur) + 34'(s_pri);
	assign left     = {gap, 17'b0};
	assign hi       = 50'(sum4) * 50'(cfg.distance_limit[31:16]);
	assign lo       = 50'(sum4) * 50'(cfg.distance_limit[15:0]);
	assign diff     = left - lo;
	assign dist_ok  = cfg.scale_by_depth ? ((left < lo) || (50'(diff[49:16]) < hi))
	                                     : (gap < {cfg.distance_limit, 1'b0});

	assign hid          = range_open_q && hidden_q;
	assign collapse_now = !hid && range_open_q && cfg.collapse_hidden
	                      && (pt_new < dsrm_pkg::OPAQUE_EPS);
	assign do_absorb    = hid || collapse_now || (range_open_q && alpha_ok && dist_ok);
	assign emit_early   = !do_absorb && range_open_q;

	always_comb begin
		n_pix_t  = pix_t_q;
		n_rng_t  = rng_t_q;
		n_open   = range_open_q;
		n_hidden = hidden_q;
		n_near   = near_front_q;
		n_far    = far_back_q;
		n_count  = count_q;
		for (int c = 0; c < CH; c++) begin
			n_color[c] = rng_color_q[c];
		end
		if (!hid) begin
			n_pix_t = pt_new;
		end
		if (collapse_now) begin
			n_hidden = 1'b1;
		end
		n_far = item.back_depth;
		if (do_absorb) begin
			n_rng_t = rt_abs;
			for (int c = 0; c < CH; c++) begin
				n_color[c] = col_abs[c];
			end
			if (count_q < COUNT_CAP) begin
				n_count = count_q + 10'd1;
			end
		end else begin
			n_rng_t = rt_open;
			n_near  = item.front_depth;
			n_count = '0;
			n_open  = 1'b1;
			for (int c = 0; c < CH; c++) begin
				n_color[c] = src[c];
			end
		end
		if (item.pixel_last) begin
			n_open   = 1'b0;
			n_hidden = 1'b0;
			n_pix_t  = dsrm_pkg::UNITY_T;
		end
	end

	assign old_out = make_out(near_front_q, far_back_q, rng_t_q, rng_color_q[0],
		rng_color_q[1], rng_color_q[2], count_q, 1'b0, cfg.give_volume);
	assign new_out = make_out(n_near, n_far, n_rng_t, n_color[0], n_color[1],
		n_color[2], n_count, 1'b1, cfg.give_volume);

	assign push.cnt    = fire ? (2'(emit_early) + 2'(item.pixel_last)) : 2'd0;
	assign push.first  = emit_early ? old_out : new_out;
	assign push.second = new_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_front_q <= '0;
			prior_back_q  <= '0;
			prior_alpha_q <= '0;
			range_open_q  <= 1'b0;
			hidden_q      <= 1'b0;
			pix_t_q       <= dsrm_pkg::UNITY_T;
			rng_t_q       <= dsrm_pkg::UNITY_T;
			near_front_q  <= '0;
			far_back_q    <= '0;
			count_q       <= '0;
			for (int c = 0; c < CH; c++) begin
				rng_color_q[c] <= '0;
			end
		end else if (fire) begin
			prior_front_q <= item.front_depth;
			prior_back_q  <= item.back_depth;
			prior_alpha_q <= a_cl;
			range_open_q  <= n_open;
			hidden_q      <= n_hidden;
			pix_t_q       <= n_pix_t;
			rng_t_q       <= n_rng_t;
			near_front_q  <= n_near;
			far_back_q    <= n_far;
			count_q       <= n_count;
			for (int c = 0; c < CH; c++) begin
				rng_color_q[c] <= n_color[c];
			end
		end
	end

	// two results only when a range closes on the last sample of a pixel
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (item.pixel_last && range_open_q))
		else $error("two results without an open range at pixel end");

	a_hidden_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		hidden_q |-> range_open_q)
		else $error("hidden collapse set with no open range");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_CAP)
		else $error("merged count beyond cap");

	a_pixel_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.pixel_last) |=> (!range_open_q && pix_t_q == dsrm_pkg::UNITY_T))
		else $error("pixel end did not reset range state");

endmodule

/* sv/dsrm_fifo.sv */
// small result queue taking up to two results per cycle, delivering one when not stalled
module dsrm_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  dsrm_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output dsrm_pkg::out_item_t out_data
);

	localparam int DEPTH = dsrm_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	dsrm_pkg::out_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q, wptr_nx;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop       = out_valid && !out_stall;
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rptr_q];
	assign room      = count_q <= CNT_W'(DEPTH - 2);
	assign wptr_nx   = wptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wptr_nx] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(push.cnt);
			rptr_q  <= rptr_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> ((count_q + CNT_W'(push.cnt)) <= CNT_W'(DEPTH)))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.cnt == 2'd0) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("queue count wrong after pop");

endmodule

/* sv/deep_sample_range_merge.sv */
// top level of the deep sample range merge block
// Merges the deep samples of a pixel, fed nearest first, into depth ranges and
// delivers one composited request per range. The block takes one sample per
// clock while in_stall is low: a sample lands in the input register, and once
// the queue has room the merge test, the transparency and color updates and
// the result formatting run in one pass against the running range state, so
// the next sample of the same pixel sees that state right away. Results go
// into a four-entry queue that drives the output port; out_valid rises once a
// result is written into the queue. A sample normally produces zero or one
// result; the last sample of a pixel that also closes an earlier range
// produces two, ordered earlier range first. in_stall rises while the queue
// has fewer than two free entries with a sample waiting, so the sustained
// rate is one sample per cycle as long as the output side drains one request
// per cycle and pixels do not end on a split. Configuration is written through
// cfg_we/cfg_idx/cfg_data while the block is idle; the user must keep to this,
// as the block does not enforce it. Writes to unknown indexes are dropped.
module deep_sample_range_merge #(
	parameter int MAX_SAMPLES = dsrm_pkg::MAX_SAMPLES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  dsrm_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output dsrm_pkg::out_item_t                    out_data,
	input  logic                                  cfg_we,
	input  logic [dsrm_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [dsrm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	dsrm_pkg::cfg_t     cfg_q;
	dsrm_pkg::in_item_t item_s1;
	dsrm_pkg::push_t    push;
	logic               valid_s1;
	logic               room;
	logic               advance;
	logic               accept;

	// input register: the sample advances into the core when the queue has room
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_by_depth  <= dsrm_pkg::RST_SCALE_BY_DEPTH;
			cfg_q.distance_limit  <= dsrm_pkg::RST_DISTANCE_LIMIT;
			cfg_q.alpha_limit     <= dsrm_pkg::RST_ALPHA_LIMIT;
			cfg_q.collapse_hidden <= dsrm_pkg::RST_COLLAPSE_HIDDEN;
			cfg_q.give_volume     <= dsrm_pkg::RST_GIVE_VOLUME;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dsrm_pkg::REG_SCALE_BY_DEPTH:  cfg_q.scale_by_depth  <= cfg_data[0];
				dsrm_pkg::REG_DISTANCE_LIMIT:  cfg_q.distance_limit  <= cfg_data;
				dsrm_pkg::REG_ALPHA_LIMIT:     cfg_q.alpha_limit     <= cfg_data[16:0];
				dsrm_pkg::REG_COLLAPSE_HIDDEN: cfg_q.collapse_hidden <= cfg_data[0];
				dsrm_pkg::REG_GIVE_VOLUME:     cfg_q.give_volume     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// merge datapath and running range state
	dsrm_core #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (item_s1),
		.cfg   (cfg_q),
		.push  (push)
	);

	// result queue toward the output port
	dsrm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

/* dv/deep_sample_range_merge_tb.sv */
// self-checking testbench for the deep sample range merge block, with its range scoreboard
import dsrm_pkg::*;

// mirrors the merge of samples into depth ranges and holds the ranges still due
class merge_scoreboard;
	localparam int COUNT_CAP = (MAX_SAMPLES - 1 < 1023) ? MAX_SAMPLES - 1 : 1023;

	cfg_t cfg;

	// running state of the pixel and of its open range
	logic [DEPTH_W-1:0] prior_front;
	logic [DEPTH_W-1:0] prior_back;
	logic [ALPHA_W-1:0] prior_alpha;
	bit                 range_open;
	bit                 hidden_collapse;
	logic [TRANS_W-1:0] pixel_t;
	logic [TRANS_W-1:0] range_t;
	logic [COLOR_W-1:0] range_color [COLOR_CHANNELS];
	logic [DEPTH_W-1:0] near_front;
	logic [DEPTH_W-1:0] far_back;
	logic [COUNT_W-1:0] range_count;

	out_item_t ranges_due [$];
	int        errors;
	int        checked;

	function new();
		cfg.scale_by_depth  = RST_SCALE_BY_DEPTH;
		cfg.distance_limit  = RST_DISTANCE_LIMIT;
		cfg.alpha_limit     = RST_ALPHA_LIMIT;
		cfg.collapse_hidden = RST_COLLAPSE_HIDDEN;
		cfg.give_volume     = RST_GIVE_VOLUME;
		prior_front     = '0;
		prior_back      = '0;
		prior_alpha     = '0;
		range_open      = 1'b0;
		hidden_collapse = 1'b0;
		pixel_t         = UNITY_T;
		range_t         = UNITY_T;
		foreach (range_color[c])
			range_color[c] = '0;
		near_front  = '0;
		far_back    = '0;
		range_count = '0;
		errors      = 0;
		checked     = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SCALE_BY_DEPTH:  cfg.scale_by_depth  = data[0];
			REG_DISTANCE_LIMIT:  cfg.distance_limit  = data[DEPTH_W-1:0];
			REG_ALPHA_LIMIT:     cfg.alpha_limit     = data[ALPHA_W-1:0];
			REG_COLLAPSE_HIDDEN: cfg.collapse_hidden = data[0];
			REG_GIVE_VOLUME:     cfg.give_volume     = data[0];
			default: ;
		endcase
	endfunction

	// transparency times (1 - alpha), truncating
	function logic [TRANS_W-1:0] fade(logic [TRANS_W-1:0] t, logic [ALPHA_W-1:0] a);
		logic [63:0] w;
		w = t;
		w = w * (ALPHA_ONE - a);
		return w[TRANS_W+15:16];
	endfunction

	function bit joins_range(in_item_t s, logic [ALPHA_W-1:0] a);
		logic [63:0] s_cur, s_pri, gap, sum, left, hi, lo, asum, alim, lim_hi, lim_lo;
		s_cur = s.front_depth;
		s_cur += s.back_depth;
		s_pri = prior_front;
		s_pri += prior_back;
		gap = (s_cur > s_pri) ? s_cur - s_pri : s_pri - s_cur;
		asum = prior_alpha;
		asum += a;
		alim = cfg.alpha_limit;
		if (asum >= (alim << 1))
			return 1'b0;
		if (!cfg.scale_by_depth)
			return gap < ({32'b0, cfg.distance_limit} << 1);
		// gap over mean depth against the ratio, split to stay within 64 bits
		sum = s_cur + s_pri;
		left = gap << 17;
		lim_hi = cfg.distance_limit[31:16];
		lim_lo = cfg.distance_limit[15:0];
		hi = sum * lim_hi;
		lo = sum * lim_lo;
		if (left < lo)
			return 1'b1;
		return ((left - lo) >> 16) < hi;
	endfunction

	function void absorb(in_item_t s, logic [ALPHA_W-1:0] a);
		logic [COLOR_W-1:0] src [COLOR_CHANNELS];
		logic [63:0] v;
		src[0] = s.red;
		src[1] = s.green;
		src[2] = s.blue;
		for (int c = 0; c < COLOR_CHANNELS; c++) begin
			v = range_t;
			v = (v * src[c]) >> 32;
			v += range_color[c];
			range_color[c] = (v > COLOR_MAX) ? COLOR_MAX : v[COLOR_W-1:0];
		end
		range_t = fade(range_t, a);
		far_back = s.back_depth;
		if (range_count < COUNT_CAP)
			range_count++;
	endfunction

	function out_item_t close_out(bit last);
		out_item_t r;
		logic [63:0] w;
		w = UNITY_T;
		w -= range_t;
		r.out_front     = near_front;
		r.out_back      = cfg.give_volume ? far_back : near_front;
		r.out_alpha     = w[32:16];
		r.out_red       = range_color[0];
		r.out_green     = range_color[1];
		r.out_blue      = range_color[2];
		r.merged_count  = range_count;
		r.last_of_pixel = last;
		return r;
	endfunction

	function void note_sample(in_item_t s);
		logic [ALPHA_W-1:0] a;
		a = (s.alpha > ALPHA_ONE) ? ALPHA_ONE : s.alpha;
		if (range_open && hidden_collapse) begin
			absorb(s, a);
		end else begin
			pixel_t = fade(pixel_t, a);
			if (range_open && cfg.collapse_hidden && pixel_t < OPAQUE_EPS) begin
				hidden_collapse = 1'b1;
				absorb(s, a);
			end else if (range_open && joins_range(s, a)) begin
				absorb(s, a);
			end else begin
				if (range_open)
					ranges_due.push_back(close_out(1'b0));
				foreach (range_color[c])
					range_color[c] = '0;
				range_t = UNITY_T;
				near_front = s.front_depth;
				range_open = 1'b1;
				absorb(s, a);
				range_count = '0;
			end
		end
		prior_front = s.front_depth;
		prior_back  = s.back_depth;
		prior_alpha = a;
		if (s.pixel_last) begin
			ranges_due.push_back(close_out(1'b1));
			range_open      = 1'b0;
			hidden_collapse = 1'b0;
			pixel_t         = UNITY_T;
		end
	endfunction

	// quiet after the first hundred
	task report(string msg);
		errors++;
		if (errors <= 100)
			$display("ERROR: %s", msg);
	endtask

	task compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report($sformatf("range %0d %s: got %h, predicted %h", checked, name, got, want));
	endtask

	task check_result(out_item_t got);
		out_item_t want;
		if (ranges_due.size() == 0) begin
			report($sformatf("request with nothing predicted: %h", got));
			return;
		end
		want = ranges_due.pop_front();
		compare_field("out_front", got.out_front, want.out_front);
		compare_field("out_back", got.out_back, want.out_back);
		compare_field("out_alpha", got.out_alpha, want.out_alpha);
		compare_field("out_red", got.out_red, want.out_red);
		compare_field("out_green", got.out_green, want.out_green);
		compare_field("out_blue", got.out_blue, want.out_blue);
		compare_field("merged_count", got.merged_count, want.merged_count);
		compare_field("last_of_pixel", got.last_of_pixel, want.last_of_pixel);
		checked++;
	endtask
endclass

module deep_sample_range_merge_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsrm_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int SETTLE_CYCLES    = 16;    // pipeline plus output queue, with margin
	localparam int HOLD_CYCLES      = 300;   // long receiver hold-off
	localparam int RANDOM_PER_PHASE = 110;
	localparam int DEEP_PIXEL_LEN   = 1026;  // enough to saturate the sample count
	localparam logic [DEPTH_W-1:0] NEAR = 32'h000A_0000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	merge_scoreboard sb = new();

	// idle controls shared by the sender, the receiver and the sequence
	bit idling  = 1'b1;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int hold_cycles = 0;
	int sent_count  = 0;
	int settings    = 1;
	int cycle_count = 0;

	deep_sample_range_merge dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d ranges still due", cycle_count,
				sb.ranges_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// output monitor: a request moves when valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// receiver: random stall bursts, plus the long hold-off counted down here
	initial begin : receiver
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic in_item_t sample_of(logic [DEPTH_W-1:0] f, logic [DEPTH_W-1:0] b,
		logic [ALPHA_W-1:0] a, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
		logic [COLOR_W-1:0] bl, logic last);
		in_item_t s;
		s.front_depth = f;
		s.back_depth  = b;
		s.alpha       = a;
		s.red         = r;
		s.green       = g;
		s.blue        = bl;
		s.pixel_last  = last;
		return s;
	endfunction

	// premultiplied-looking color half of the time, any value otherwise
	function automatic logic [COLOR_W-1:0] tint(logic [ALPHA_W-1:0] a);
		logic [31:0] v;
		if ($urandom_range(0, 1) == 1)
			v = $urandom;
		else
			v = a * $urandom_range(0, 255);
		return v[COLOR_W-1:0];
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the caller must drive valid right away
	task automatic send_sample(input in_item_t s);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s);
		sent_count++;
		@(negedge clk);
	endtask

	// one pixel nearest first; bury makes the second sample opaque
	task automatic send_pixel(input int len, input bit closed, input bit bury);
		in_item_t s;
		logic [DEPTH_W-1:0] depth, step, thick;
		logic [ALPHA_W-1:0] a, a_cap;
		int style, k;
		style = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0)
			depth = $urandom;
		else
			depth = $urandom_range(0, 32'h00FF_FFFF);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: a = ALPHA_W'($urandom_range(0, 2048));
				1: a = ALPHA_W'($urandom_range(0, ALPHA_ONE));
				2: begin
					if ($urandom_range(0, 3) == 0)
						a = ALPHA_ONE;
					else
						a = ALPHA_W'($urandom_range(20000, ALPHA_ONE));
				end
				default: begin
					// sparse layers, now and then an alpha above one
					if ($urandom_range(0, 8) == 0)
						a = ALPHA_W'($urandom_range(ALPHA_ONE + 1, 17'h1FFFF));
					else
						a = ALPHA_W'($urandom_range(0, 16384));
				end
			endcase
			if (bury && i == 1)
				a = ALPHA_ONE;
			a_cap = (a > ALPHA_ONE) ? ALPHA_ONE : a;
			if ($urandom_range(0, 3) == 0)
				thick = '0;
			else
				thick = $urandom_range(0, 32'h4000);
			s.front_depth = depth;
			s.back_depth  = depth + thick;
			s.alpha       = a;
			s.red         = tint(a_cap);
			s.green       = tint(a_cap);
			s.blue        = tint(a_cap);
			s.pixel_last  = closed && (i == len - 1);
			send_sample(s);
			k = (style == 3) ? $urandom_range(6, 9) : $urandom_range(0, 9);
			if (k < 6)
				step = $urandom_range(0, 256);
			else if (k < 8)
				step = $urandom_range(0, 32'h0001_0000);
			else if (k < 9)
				step = $urandom_range(0, 32'h0100_0000);
			else
				step = $urandom;
			depth = depth + step;
		end
	endtask

	// mostly proper pixels, some left open, some raw noise
	task automatic run_mix(input int budget);
		in_item_t s;
		int start, k;
		start = sent_count;
		while (sent_count - start < budget) begin
			tx_idle = idling && ($urandom_range(0, 3) != 0);
			rx_idle = idling && ($urandom_range(0, 3) != 0);
			k = $urandom_range(0, 19);
			if (k < 15) begin
				send_pixel(($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8),
					1'b1, $urandom_range(0, 5) == 0);
			end else if (k < 17) begin
				send_pixel($urandom_range(1, 6), 1'b0, 1'b0);
			end else begin
				s.front_depth = $urandom;
				s.back_depth  = $urandom;
				s.alpha       = ALPHA_W'($urandom_range(0, 17'h1FFFF));
				s.red         = COLOR_W'($urandom);
				s.green       = COLOR_W'($urandom);
				s.blue        = COLOR_W'($urandom);
				s.pixel_last  = 1'($urandom_range(0, 1));
				send_sample(s);
			end
		end
	endtask

	// stop offering, let every predicted range arrive, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.ranges_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// all five registers, one per cycle, enable held high across the burst
	task automatic write_config(input cfg_t c);
		logic [CFG_IDX_W-1:0]  idx [5];
		logic [CFG_DATA_W-1:0] val [5];
		idx[0] = REG_SCALE_BY_DEPTH;  val[0] = {31'b0, c.scale_by_depth};
		idx[1] = REG_DISTANCE_LIMIT;  val[1] = c.distance_limit;
		idx[2] = REG_ALPHA_LIMIT;     val[2] = {15'b0, c.alpha_limit};
		idx[3] = REG_COLLAPSE_HIDDEN; val[3] = {31'b0, c.collapse_hidden};
		idx[4] = REG_GIVE_VOLUME;     val[4] = {31'b0, c.give_volume};
		for (int i = 0; i < 5; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= idx[i];
			cfg_data <= val[i];
			sb.write_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : sequence_main
		cfg_t plan [5];

		// plain distance, mid alpha, flat ranges
		plan[0].scale_by_depth  = 1'b0;
		plan[0].distance_limit  = $urandom_range(32'h100, 32'h0004_0000);
		plan[0].alpha_limit     = 17'd32768;
		plan[0].collapse_hidden = 1'b1;
		plan[0].give_volume     = 1'b0;
		// zero limits: nothing ever merges, so results come thick
		plan[1].scale_by_depth  = 1'b0;
		plan[1].distance_limit  = '0;
		plan[1].alpha_limit     = '0;
		plan[1].collapse_hidden = 1'b0;
		plan[1].give_volume     = 1'b1;
		// widest ratio and alpha limit
		plan[2].scale_by_depth  = 1'b1;
		plan[2].distance_limit  = 32'hFFFF_FFFF;
		plan[2].alpha_limit     = ALPHA_ONE;
		plan[2].collapse_hidden = 1'b0;
		plan[2].give_volume     = 1'b1;
		// ratio of one
		plan[3].scale_by_depth  = 1'b1;
		plan[3].distance_limit  = 32'h0001_0000;
		plan[3].alpha_limit     = ALPHA_ONE;
		plan[3].collapse_hidden = 1'b1;
		plan[3].give_volume     = 1'b0;
		// anything goes, run without idling
		plan[4].scale_by_depth  = 1'($urandom_range(0, 1));
		plan[4].distance_limit  = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 32'h2_0000);
		plan[4].alpha_limit     = ALPHA_W'($urandom_range(0, ALPHA_ONE));
		plan[4].collapse_hidden = 1'($urandom_range(0, 1));
		plan[4].give_volume     = 1'($urandom_range(0, 1));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pixels at the reset settings
		// all-zero and all-ones single-sample pixels
		send_sample(sample_of('0, '0, '0, '0, '0, '0, 1'b1));
		send_sample(sample_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, ALPHA_ONE,
			COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b1));
		// alpha above one is taken as one
		send_sample(sample_of(32'h0001_0000, 32'h0001_0100, 17'h1FFFF,
			24'h00_8000, 24'h01_0000, 24'h7F_FFFF, 1'b1));
		// close thin layers merge, color sum saturates
		send_sample(sample_of(NEAR, NEAR + 64, 17'd1000, COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b0));
		send_sample(sample_of(NEAR + 128, NEAR + 192, 17'd1000, COLOR_MAX, COLOR_MAX, COLOR_MAX, 1'b0));
		send_sample(sample_of(NEAR + 256, NEAR + 320, 17'd1000,
			24'h80_0000, 24'h80_0000, 24'h80_0000, 1'b1));
		// far last sample closes the earlier range first: two results
		send_sample(sample_of(NEAR, NEAR + 64, 17'd500, 24'h10_0000, 24'h20_0000, 24'h30_0000, 1'b0));
		send_sample(sample_of(NEAR << 2, (NEAR << 2) + 64, 17'd500,
			24'h01_0000, 24'h02_0000, 24'h03_0000, 1'b1));
		// opaque first sample cannot collapse on its own, the next one does
		send_sample(sample_of(NEAR, NEAR, ALPHA_ONE, 24'hFF_0000, 24'h00_FF00, 24'h00_00FF, 1'b0));
		send_sample(sample_of(32'h0100_0000, 32'h0100_1000, 17'd300,
			24'h12_3456, 24'h65_4321, 24'h0F_0F0F, 1'b0));
		send_sample(sample_of(32'h0800_0000, 32'h0900_0000, ALPHA_ONE,
			COLOR_MAX, 24'h00_0001, 24'h55_5555, 1'b1));
		// no pixel end: the pixel carries on into the next samples
		send_sample(sample_of(NEAR, NEAR + 64, 17'd200, 24'h00_1000, 24'h00_2000, 24'h00_3000, 1'b0));
		send_sample(sample_of(NEAR + 64, NEAR + 128, 17'd200,
			24'h00_1000, 24'h00_2000, 24'h00_3000, 1'b0));
		send_sample(sample_of(32'h4000_0000, 32'h4000_0040, 17'd65535,
			24'hAA_AAAA, 24'h55_5555, 24'hFF_FFFF, 1'b1));

		run_mix(RANDOM_PER_PHASE);
		drain();

		for (int p = 0; p < 5; p++) begin
			if (p == 4) begin
				// quiet tail: no idling on either side
				idling  = 1'b0;
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			write_config(plan[p]);
			settings++;
			// one very deep buried pixel to saturate the sample count
			if (p == 0)
				send_pixel(DEEP_PIXEL_LEN, 1'b1, 1'b1);
			// receiver holds off while samples keep coming, filling the queue
			if (p == 1)
				hold_cycles = HOLD_CYCLES;
			run_mix(RANDOM_PER_PHASE);
			drain();
		end

		$display("covered %0d samples under %0d register settings, %0d ranges compared",
			sent_count, settings, sb.checked);
		$display("included a %0d-sample buried pixel and a %0d-cycle receiver hold-off",
			DEEP_PIXEL_LEN, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
sv/dsrm_pkg.sv
sv/dsrm_core.sv
sv/dsrm_fifo.sv
sv/deep_sample_range_merge.sv
dv/deep_sample_range_merge_tb.sv
